// ----- sv/sobs_pkg.sv -----
// Shared types, codes and sizes for the set of bounded stacks unit.
// Used by sobs_ctrl and set_of_bounded_stacks_unit; depends on nothing.
package sobs_pkg;

    // Sub-stack count and depth of each sub-stack.
    localparam int NUM_STACKS  = 4;
    localparam int STACK_DEPTH = 16;

    localparam int STACK_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int DATA_W = 32;

    // Request codes.
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_POP_AT = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] push_value;
        logic [1:0]               stack_index;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic                     all_empty;
        logic                     all_full;
    } t_out_beat;

    // One step's decision, from the control unit to the datapath.
    typedef struct packed {
        logic                     wr_en;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [DATA_W-1:0] wr_data;
        logic [ADDR_W-1:0]        rd_addr;
        logic                     fwd;
        logic                     top_zero;
        logic [1:0]               status;
        logic                     all_empty;
        logic                     all_full;
    } t_step;

endpackage

// ----- sv/set_of_bounded_stacks_unit.sv -----
// Top level of the set of bounded stacks unit: handshake, element RAM, result register.
// Depends on sobs_pkg, sobs_ctrl and sobs_ram.
//
// One logical stack built from sobs_pkg::NUM_STACKS sub-stacks of
// sobs_pkg::STACK_DEPTH 32-bit entries each, held in a single element RAM.
// Each input beat (push, pop, or pop from a named sub-stack) yields exactly
// one result beat with a status, the new top of the current sub-stack (zero
// when it is empty) and the all-empty / all-full flags. An item is handled
// in order: in the accept cycle the fill counts and current index are
// updated, a push is written to the RAM, and the read of the new top is
// issued; once the result register is free, the registered RAM data (or the
// just-pushed value) is loaded into the result register. The result
// register frees the input side: a new item is accepted while a finished
// result waits, as long as no earlier item is still waiting for its RAM
// read. Fill counts and the current index are cleared by reset at once; the
// RAM needs no clearing pass, since only entries below a fill count ever
// reach the result register.
module set_of_bounded_stacks_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sobs_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sobs_pkg::t_out_beat o_out_data
);

    sobs_pkg::t_step step;
    logic            accept;
    logic            out_free;
    logic            load;
    logic [sobs_pkg::DATA_W-1:0] rd_data;

    // Pending item: waiting for its RAM read data to be loaded into the result register.
    logic                        r_pend;
    logic                        r_fwd;
    logic                        r_top_zero;
    logic signed [sobs_pkg::DATA_W-1:0] r_fwd_val;
    logic [1:0]                  r_status;
    logic                        r_all_empty;
    logic                        r_all_full;

    // Result register.
    logic                r_out_valid;
    sobs_pkg::t_out_beat r_out;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign load       = r_pend && out_free;
    // Hold off a new beat while the previous item still owns the RAM read data.
    assign o_in_stall = r_pend;
    assign accept     = i_in_valid && !r_pend;

    sobs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_data),
        .o_step   (step)
    );

    sobs_ram #(
        .WIDTH (sobs_pkg::DATA_W),
        .DEPTH (sobs_pkg::MEM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept && step.wr_en),
        .i_wr_addr (step.wr_addr),
        .i_wr_data (step.wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (step.rd_addr),
        .o_rd_data (rd_data)
    );

    // Capture the decision of the accepted beat; RAM data follows next cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd       <= step.fwd;
            r_fwd_val   <= step.wr_data;
            r_top_zero  <= step.top_zero;
            r_status    <= step.status;
            r_all_empty <= step.all_empty;
            r_all_full  <= step.all_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pend <= 1'b1;
            end else if (load) begin
                r_pend <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result beat: zero for an empty sub-stack, forward a fresh push.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.status    <= r_status;
            r_out.all_empty <= r_all_empty;
            r_out.all_full  <= r_all_full;
            if (r_top_zero) begin
                r_out.top_value <= '0;
            end else if (r_fwd) begin
                r_out.top_value <= r_fwd_val;
            end else begin
                r_out.top_value <= rd_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sv/sobs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module sobs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/sobs_ctrl.sv -----
// Fill counts, current sub-stack index and the per-request decision logic.
// Depends on sobs_pkg.
module sobs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  sobs_pkg::t_in_beat i_req,
    output sobs_pkg::t_step    o_step
);

    logic [sobs_pkg::COUNT_W-1:0] r_cnt [sobs_pkg::NUM_STACKS];
    logic [sobs_pkg::COUNT_W-1:0] n_cnt [sobs_pkg::NUM_STACKS];
    logic [sobs_pkg::STACK_W-1:0] r_cur;
    logic [sobs_pkg::STACK_W-1:0] n_cur;

    localparam logic [sobs_pkg::COUNT_W-1:0] FULL_CNT =
        sobs_pkg::COUNT_W'(sobs_pkg::STACK_DEPTH);
    localparam logic [sobs_pkg::STACK_W-1:0] LAST_STACK =
        sobs_pkg::STACK_W'(sobs_pkg::NUM_STACKS - 1);

    always_comb begin
        logic [sobs_pkg::COUNT_W-1:0] n_top;
        logic [sobs_pkg::STACK_W-1:0] idx;
        logic                         idx_ok;

        n_cnt  = r_cnt;
        n_cur  = r_cur;
        o_step = '0;
        o_step.status  = sobs_pkg::ST_DONE;
        o_step.wr_data = i_req.push_value;
        idx    = sobs_pkg::STACK_W'(i_req.stack_index);
        idx_ok = (32'(i_req.stack_index) < sobs_pkg::NUM_STACKS);

        case (i_req.req_type)
            sobs_pkg::REQ_PUSH: begin
                // Advance to the next sub-stack when the current one is full.
                if (r_cnt[r_cur] >= FULL_CNT) begin
                    if (r_cur != LAST_STACK) begin
                        n_cur = r_cur + 1'b1;
                    end else begin
                        o_step.status = sobs_pkg::ST_FULL;
                    end
                end
                if (o_step.status == sobs_pkg::ST_DONE) begin
                    if (r_cnt[n_cur] < FULL_CNT) begin
                        o_step.wr_en   = 1'b1;
                        o_step.wr_addr =
                            sobs_pkg::ADDR_W'(n_cur) *
                            sobs_pkg::ADDR_W'(sobs_pkg::STACK_DEPTH) +
                            sobs_pkg::ADDR_W'(r_cnt[n_cur]);
                        n_cnt[n_cur] = r_cnt[n_cur] + 1'b1;
                    end else begin
                        o_step.status = sobs_pkg::ST_FULL;
                    end
                end
            end
            sobs_pkg::REQ_POP: begin
                // Step back first when the current sub-stack is already empty.
                if (r_cnt[r_cur] == '0 && r_cur != '0) begin
                    n_cur = r_cur - 1'b1;
                end
                if (r_cnt[n_cur] == '0) begin
                    o_step.status = sobs_pkg::ST_EMPTY;
                end else begin
                    n_cnt[n_cur] = r_cnt[n_cur] - 1'b1;
                    if (n_cnt[n_cur] == '0 && n_cur != '0) begin
                        n_cur = n_cur - 1'b1;
                    end
                end
            end
            sobs_pkg::REQ_POP_AT: begin
                if (!idx_ok || r_cnt[idx] == '0) begin
                    o_step.status = sobs_pkg::ST_EMPTY;
                end else begin
                    n_cnt[idx] = r_cnt[idx] - 1'b1;
                end
            end
            default: begin
            end
        endcase

        n_top = n_cnt[n_cur];
        o_step.top_zero  = (n_top == '0);
        o_step.rd_addr   = sobs_pkg::ADDR_W'(n_cur) *
                           sobs_pkg::ADDR_W'(sobs_pkg::STACK_DEPTH) +
                           sobs_pkg::ADDR_W'(n_top) - 1'b1;
        // A successful push makes the pushed value the new top.
        o_step.fwd       = o_step.wr_en;
        o_step.all_empty = (n_cur == '0) && (n_top == '0);
        o_step.all_full  = (n_cur == LAST_STACK) && (n_top >= FULL_CNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            for (int i = 0; i < sobs_pkg::NUM_STACKS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_accept) begin
            r_cur <= n_cur;
            r_cnt <= n_cnt;
        end
    end

endmodule
